/* hdl/escu_pkg.sv */
// ----------------------------------------------------------------------------
// escu_pkg
// Types, constants and arithmetic helpers for the sensor compensation unit.
// ----------------------------------------------------------------------------
package escu_pkg;

	localparam int DIV_STEPS = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_HUM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUM       = 3'd4;

	localparam logic signed [31:0] TEMP_MIN    = -32'sd4000;
	localparam logic signed [31:0] TEMP_MAX    = 32'sd8500;
	localparam logic [31:0]        PRESS_MIN   = 32'd3000000;
	localparam logic [31:0]        PRESS_MAX   = 32'd11000000;
	localparam logic signed [31:0] HUM_RAW_MAX = 32'sd419430400;
	localparam logic [16:0]        HUM_MAX     = 17'd102400;

	localparam logic [63:0] PRESS_TF_OFS = 64'd128000;
	localparam logic [31:0] HUM_TF_OFS   = 32'd76800;
	localparam logic [63:0] PRESS_BASE   = 64'd140737488355328;
	localparam logic [63:0] RAW_P_FULL   = 64'd1048576;

	// divider stage: remainder, dividend/quotient shift word, divisor
	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] nq;
		logic [63:0] den;
		logic        neg;
		logic        fb;
		logic [14:0] ts;
		logic [16:0] hum;
	} dv_t;

	// signed divide by 2^k, truncating toward zero
	function automatic logic [31:0] sdiv32_p2(input logic [31:0] v, input int unsigned k);
		logic [31:0]        bias;
		logic signed [31:0] t;
		bias = v[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
		t = $signed(v + bias);
		return 32'(t >>> k);
	endfunction

	function automatic logic [63:0] sdiv64_p2(input logic [63:0] v, input int unsigned k);
		logic [63:0]        bias;
		logic signed [63:0] t;
		bias = v[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
		t = $signed(v + bias);
		return 64'(t >>> k);
	endfunction

	// one restoring step, one quotient bit
	function automatic dv_t div_step(input dv_t d);
		dv_t         r;
		logic [64:0] t;
		logic [64:0] diff;
		r = d;
		t = {d.rem, d.nq[63]};
		diff = t - {1'b0, d.den};
		if (!diff[64]) begin
			r.rem = diff[63:0];
			r.nq  = {d.nq[62:0], 1'b1};
		end else begin
			r.rem = t[63:0];
			r.nq  = {d.nq[62:0], 1'b0};
		end
		return r;
	endfunction

endpackage

/* hdl/escu_sample_if.sv */
// ----------------------------------------------------------------------------
// escu_sample_if
// Raw measurement request channel.
// ----------------------------------------------------------------------------
interface escu_sample_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_temperature;
	logic [19:0] raw_pressure;
	logic [15:0] raw_humidity;

	modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
	modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

/* hdl/escu_result_if.sv */
// ----------------------------------------------------------------------------
// escu_result_if
// Compensated result request channel.
// ----------------------------------------------------------------------------
interface escu_result_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] temperature_centi;
	logic [23:0]        pressure_centipascal;
	logic [16:0]        humidity_q10;
	logic               pressure_fallback;

	modport source (output valid, temperature_centi, pressure_centipascal, humidity_q10,
		pressure_fallback, input ready);
	modport sink (input valid, temperature_centi, pressure_centipascal, humidity_q10,
		pressure_fallback, output ready);
endinterface

/* hdl/escu_cfg_if.sv */
// ----------------------------------------------------------------------------
// escu_cfg_if
// Calibration register write channel.
// ----------------------------------------------------------------------------
interface escu_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/escu_div.sv */
// ----------------------------------------------------------------------------
// escu_div
// Pipelined unsigned 64/64 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module escu_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  escu_pkg::dv_t in_data,
	output logic          out_vld,
	output escu_pkg::dv_t out_data
);
	import escu_pkg::*;

	dv_t                  stg_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DIV_STEPS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= div_step(in_data);
			for (int i = 1; i < DIV_STEPS; i++) begin
				stg_s[i] <= div_step(stg_s[i-1]);
			end
		end
	end

	assign out_vld  = vld_s[DIV_STEPS-1];
	assign out_data = stg_s[DIV_STEPS-1];

endmodule

/* hdl/env_sensor_integer_compensation_unit.sv */
// ----------------------------------------------------------------------------
// env_sensor_integer_compensation_unit
// Integer compensation of temperature, pressure and humidity readings.
//
//   channel  dir  handshake      payload
//   sample   in   valid/ready    raw_temperature, raw_pressure, raw_humidity
//   result   out  valid/ready    temperature_centi, pressure_centipascal,
//                                humidity_q10, pressure_fallback
//   cfg      in   valid/ready    index, data (ready always high)
//
// One request per cycle while the skid register is empty; the pipe holds the
// 64-stage divider for the pressure quotient plus 12 front and 7 back stages.
// Reset clears all valid bits and the calibration registers.
// An output skid register holds one result, so the pipe keeps moving
// while a result waits; it stalls only while the skid register is full.
// ----------------------------------------------------------------------------
module env_sensor_integer_compensation_unit (
	input  logic          clk,
	input  logic          arst_n,
	escu_sample_if.sink   sample,
	escu_result_if.source result,
	escu_cfg_if.sink      cfg
);
	import escu_pkg::*;

	typedef struct packed {
		logic [19:0] rp;
		logic [15:0] rh;
		logic [31:0] am;
		logic [31:0] bb;
		logic [31:0] ta;
		logic [31:0] bm;
		logic [31:0] tf;
		logic [14:0] ts;
		logic [32:0] x;
		logic [31:0] hd;
		logic [63:0] xx;
		logic [63:0] xp5;
		logic [63:0] xp2;
		logic [63:0] xxp6;
		logic [63:0] xxp3;
		logic [63:0] y;
		logic [63:0] x2;
		logic [63:0] m;
		logic [63:0] x3;
		logic [63:0] num;
		logic [31:0] hg;
		logic [31:0] he;
		logic [31:0] hf;
		logic [31:0] hk;
		logic [31:0] hee;
		logic [31:0] hff;
		logic [31:0] gm;
		logic [31:0] gh2;
		logic [31:0] f2;
		logic [31:0] sq;
		logic [31:0] gh1;
	} fs_t;

	typedef struct packed {
		logic [63:0] z;
		logic [63:0] q13;
		logic [63:0] zp8;
		logic [63:0] t;
		logic [63:0] y2;
		logic [63:0] ll;
		logic [31:0] cr;
		logic [63:0] u;
		logic [63:0] zz;
		logic [63:0] hh;
		logic [23:0] pres;
		logic        fb;
		logic [14:0] ts;
		logic [16:0] hum;
	} pt_t;

	typedef struct packed {
		logic [14:0] ts;
		logic [23:0] pres;
		logic [16:0] hum;
		logic        fb;
	} res_t;

	// calibration registers
	logic [47:0] temp_q;
	logic [63:0] plo_q;
	logic [63:0] phi_q;
	logic [47:0] phc_q;
	logic [39:0] hc_q;

	logic [31:0]        t1_w, t2_w, t3_w;
	logic [63:0]        p1_w;
	logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0]        h1_w, h2_w, h3_w, h4_w, h5_w, h6_w;

	logic en;

	fs_t fr_s1, fr_s2, fr_s3, fr_s4, fr_s5, fr_s6, fr_s7, fr_s8, fr_s9, fr_s10, fr_s11;
	fs_t nx1, nx2, nx3, nx4, nx5, nx6, nx7, nx8, nx9, nx10, nx11;
	dv_t dv_s12, nx12;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12;

	logic dv_out_vld;
	dv_t  dv_out;

	pt_t pt_p1, pt_p2, pt_p3, pt_p4, pt_p5, pt_p6, pt_p7;
	pt_t np1, np2, np3, np4, np5, np6, np7;
	logic vld_p1, vld_p2, vld_p3, vld_p4, vld_p5, vld_p6, vld_p7;

	logic               skid_vld_q;
	res_t               skid_q;
	res_t               tail_w;
	res_t               out_w;

	logic [31:0]        a0_w, b0_w;
	logic [31:0]        tq_w;
	logic signed [65:0] xx_full_w;
	logic signed [48:0] xp5_full_w, xp2_full_w;
	logic [31:0]        k2_w;
	logic [31:0]        hsat_w;
	logic [31:0]        pv_w;

	// ------------------------------------------------------------------------
	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			plo_q  <= '0;
			phi_q  <= '0;
			phc_q  <= '0;
			hc_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_TEMP:      temp_q <= cfg.data[47:0];
				REG_PRESS_LO:  plo_q  <= cfg.data;
				REG_PRESS_HI:  phi_q  <= cfg.data;
				REG_PRESS_HUM: phc_q  <= cfg.data[47:0];
				REG_HUM:       hc_q   <= cfg.data[39:0];
				default: ;
			endcase
		end
	end

	assign t1_w = {16'd0, temp_q[15:0]};
	assign t2_w = {{16{temp_q[31]}}, temp_q[31:16]};
	assign t3_w = {{16{temp_q[47]}}, temp_q[47:32]};
	assign p1_w = {48'd0, plo_q[15:0]};
	assign p2   = $signed(plo_q[31:16]);
	assign p3   = $signed(plo_q[47:32]);
	assign p4   = $signed(plo_q[63:48]);
	assign p5   = $signed(phi_q[15:0]);
	assign p6   = $signed(phi_q[31:16]);
	assign p7   = $signed(phi_q[47:32]);
	assign p8   = $signed(phi_q[63:48]);
	assign p9   = $signed(phc_q[15:0]);
	assign h1_w = {24'd0, phc_q[23:16]};
	assign h2_w = {{16{phc_q[39]}}, phc_q[39:24]};
	assign h3_w = {24'd0, phc_q[47:40]};
	assign h4_w = {{16{hc_q[15]}}, hc_q[15:0]};
	assign h5_w = {{16{hc_q[31]}}, hc_q[31:16]};
	assign h6_w = {{24{hc_q[39]}}, hc_q[39:32]};

	// ------------------------------------------------------------------------
	// front stages: temperature, pressure terms, humidity
	assign en           = !skid_vld_q;
	assign sample.ready = en;

	assign a0_w = {15'd0, sample.raw_temperature[19:3]} - (t1_w << 1);
	assign b0_w = {16'd0, sample.raw_temperature[19:4]} - t1_w;

	always_comb begin
		nx1    = '0;
		nx1.rp = sample.raw_pressure;
		nx1.rh = sample.raw_humidity;
		nx1.am = a0_w * t2_w;
		nx1.bb = b0_w * b0_w;
	end

	always_comb begin
		nx2    = fr_s1;
		nx2.ta = sdiv32_p2(fr_s1.am, 11);
		nx2.bm = sdiv32_p2(fr_s1.bb, 12) * t3_w;
	end

	always_comb begin
		nx3    = fr_s2;
		nx3.tf = fr_s2.ta + sdiv32_p2(fr_s2.bm, 14);
	end

	assign tq_w = sdiv32_p2(fr_s3.tf * 32'd5 + 32'd128, 8);

	always_comb begin
		nx4 = fr_s3;
		if ($signed(tq_w) < TEMP_MIN) begin
			nx4.ts = 15'(TEMP_MIN);
		end else if ($signed(tq_w) > TEMP_MAX) begin
			nx4.ts = 15'(TEMP_MAX);
		end else begin
			nx4.ts = tq_w[14:0];
		end
		nx4.x  = {fr_s3.tf[31], fr_s3.tf} - PRESS_TF_OFS[32:0];
		nx4.hd = fr_s3.tf - HUM_TF_OFS;
	end

	assign xx_full_w  = $signed(fr_s4.x) * $signed(fr_s4.x);
	assign xp5_full_w = $signed(fr_s4.x) * p5;
	assign xp2_full_w = $signed(fr_s4.x) * p2;

	always_comb begin
		nx5     = fr_s4;
		nx5.xx  = xx_full_w[63:0];
		nx5.xp5 = 64'(xp5_full_w) << 17;
		nx5.xp2 = 64'(xp2_full_w) << 12;
		nx5.hg  = h5_w * fr_s4.hd;
		nx5.he  = fr_s4.hd * h6_w;
		nx5.hf  = fr_s4.hd * h3_w;
	end

	always_comb begin
		nx6      = fr_s5;
		nx6.xxp6 = $signed(fr_s5.xx) * p6;
		nx6.xxp3 = $signed(fr_s5.xx) * p3;
		nx6.hk   = sdiv32_p2({2'd0, fr_s5.rh, 14'd0} - (h4_w << 20) - fr_s5.hg + 32'd16384, 15);
		nx6.hee  = sdiv32_p2(fr_s5.he, 10);
		nx6.hff  = sdiv32_p2(fr_s5.hf, 11);
	end

	always_comb begin
		nx7    = fr_s6;
		nx7.y  = fr_s6.xxp6 + fr_s6.xp5 + {{13{p4[15]}}, p4, 35'd0};
		nx7.x2 = sdiv64_p2(fr_s6.xxp3, 8) + fr_s6.xp2;
		nx7.gm = fr_s6.hee * (fr_s6.hff + 32'd32768);
	end

	always_comb begin
		nx8     = fr_s7;
		nx8.m   = (PRESS_BASE + fr_s7.x2) * p1_w;
		nx8.gh2 = (sdiv32_p2(fr_s7.gm, 10) + 32'd2097152) * h2_w;
	end

	always_comb begin
		nx9     = fr_s8;
		nx9.x3  = sdiv64_p2(fr_s8.m, 33);
		nx9.num = (((RAW_P_FULL - {44'd0, fr_s8.rp}) << 31) - fr_s8.y) * 64'd3125;
		nx9.f2  = fr_s8.hk * sdiv32_p2(fr_s8.gh2 + 32'd8192, 14);
	end

	always_comb begin
		nx10    = fr_s9;
		nx10.sq = sdiv32_p2(fr_s9.f2, 15) * sdiv32_p2(fr_s9.f2, 15);
	end

	always_comb begin
		nx11     = fr_s10;
		nx11.gh1 = sdiv32_p2(fr_s10.sq, 7) * h1_w;
	end

	assign k2_w = fr_s11.f2 - sdiv32_p2(fr_s11.gh1, 4);

	always_comb begin
		if ($signed(k2_w) < 32'sd0) begin
			hsat_w = '0;
		end else if ($signed(k2_w) > HUM_RAW_MAX) begin
			hsat_w = HUM_RAW_MAX;
		end else begin
			hsat_w = k2_w;
		end
	end

	// divider setup: magnitudes and quotient sign
	always_comb begin
		nx12.rem = '0;
		nx12.nq  = fr_s11.num[63] ? (64'd0 - fr_s11.num) : fr_s11.num;
		nx12.den = fr_s11.x3[63] ? (64'd0 - fr_s11.x3) : fr_s11.x3;
		nx12.neg = fr_s11.num[63] ^ fr_s11.x3[63];
		nx12.fb  = (fr_s11.x3 == 64'd0);
		nx12.ts  = fr_s11.ts;
		nx12.hum = hsat_w[28:12];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s1  <= nx1;
			fr_s2  <= nx2;
			fr_s3  <= nx3;
			fr_s4  <= nx4;
			fr_s5  <= nx5;
			fr_s6  <= nx6;
			fr_s7  <= nx7;
			fr_s8  <= nx8;
			fr_s9  <= nx9;
			fr_s10 <= nx10;
			fr_s11 <= nx11;
			dv_s12 <= nx12;
			pt_p1  <= np1;
			pt_p2  <= np2;
			pt_p3  <= np3;
			pt_p4  <= np4;
			pt_p5  <= np5;
			pt_p6  <= np6;
			pt_p7  <= np7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_p1  <= 1'b0;
			vld_p2  <= 1'b0;
			vld_p3  <= 1'b0;
			vld_p4  <= 1'b0;
			vld_p5  <= 1'b0;
			vld_p6  <= 1'b0;
			vld_p7  <= 1'b0;
		end else if (en) begin
			vld_s1  <= sample.valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_p1  <= dv_out_vld;
			vld_p2  <= vld_p1;
			vld_p3  <= vld_p2;
			vld_p4  <= vld_p3;
			vld_p5  <= vld_p4;
			vld_p6  <= vld_p5;
			vld_p7  <= vld_p6;
		end
	end

	// ------------------------------------------------------------------------
	// pressure quotient
	escu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s12),
		.in_data  (dv_s12),
		.out_vld  (dv_out_vld),
		.out_data (dv_out)
	);

	// ------------------------------------------------------------------------
	// back stages: pressure correction terms
	always_comb begin
		np1     = '0;
		np1.z   = dv_out.neg ? (64'd0 - dv_out.nq) : dv_out.nq;
		np1.q13 = sdiv64_p2(np1.z, 13);
		np1.fb  = dv_out.fb;
		np1.ts  = dv_out.ts;
		np1.hum = dv_out.hum;
	end

	always_comb begin
		np2     = pt_p1;
		np2.zp8 = $signed(pt_p1.z) * p8;
		np2.t   = $signed(pt_p1.q13) * p9;
	end

	// low 64 bits of t * q13 from 32-bit partial products
	always_comb begin
		np3    = pt_p2;
		np3.y2 = sdiv64_p2(pt_p2.zp8, 19);
		np3.ll = pt_p2.t[31:0] * pt_p2.q13[31:0];
		np3.cr = pt_p2.t[31:0] * pt_p2.q13[63:32] + pt_p2.t[63:32] * pt_p2.q13[31:0];
	end

	always_comb begin
		np4   = pt_p3;
		np4.u = pt_p3.ll + {pt_p3.cr, 32'd0};
	end

	always_comb begin
		np5    = pt_p4;
		np5.zz = sdiv64_p2(pt_p4.z + sdiv64_p2(pt_p4.u, 25) + pt_p4.y2, 8)
			+ {{44{p7[15]}}, p7, 4'd0};
	end

	always_comb begin
		np6    = pt_p5;
		np6.hh = sdiv64_p2(pt_p5.zz, 1) * 64'd100;
	end

	assign pv_w = sdiv64_p2(pt_p6.hh, 7) >> 0 == 64'd0 ? 32'd0 : 32'(sdiv64_p2(pt_p6.hh, 7));

	always_comb begin
		np7 = pt_p6;
		if (pt_p6.fb || pv_w < PRESS_MIN) begin
			np7.pres = PRESS_MIN[23:0];
		end else if (pv_w > PRESS_MAX) begin
			np7.pres = PRESS_MAX[23:0];
		end else begin
			np7.pres = pv_w[23:0];
		end
	end

	// ------------------------------------------------------------------------
	// output skid register
	assign tail_w = '{ts: pt_p7.ts, pres: pt_p7.pres, hum: pt_p7.hum, fb: pt_p7.fb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (!skid_vld_q) begin
			skid_vld_q <= vld_p7 && !result.ready;
		end else if (result.ready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_q <= tail_w;
		end
	end

	assign out_w                       = skid_vld_q ? skid_q : tail_w;
	assign result.valid                = skid_vld_q || vld_p7;
	assign result.temperature_centi    = $signed(out_w.ts);
	assign result.pressure_centipascal = out_w.pres;
	assign result.humidity_q10         = out_w.hum;
	assign result.pressure_fallback    = out_w.fb;

endmodule

/* hdl/escu_chk.sv */
// ----------------------------------------------------------------------------
// escu_chk
// Port-level checks on the result channel of the compensation unit.
// ----------------------------------------------------------------------------
module escu_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [14:0] temperature_centi,
	input logic [23:0]       pressure_centipascal,
	input logic [16:0]       humidity_q10,
	input logic              pressure_fallback
);
	import escu_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(temperature_centi) && $stable(humidity_q10)
			&& $stable(pressure_centipascal) && $stable(pressure_fallback))
		else $error("result payload changed while stalled");

	a_press_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pressure_centipascal >= PRESS_MIN[23:0]
			&& pressure_centipascal <= PRESS_MAX[23:0])
		else $error("pressure out of range");

	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pressure_fallback |-> pressure_centipascal == PRESS_MIN[23:0])
		else $error("fallback without minimum pressure");

	a_temp_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_centi >= 15'(TEMP_MIN) && temperature_centi <= 15'(TEMP_MAX)
			&& humidity_q10 <= HUM_MAX)
		else $error("temperature or humidity out of range");

endmodule

bind env_sensor_integer_compensation_unit escu_chk u_escu_chk (
	.clk                  (clk),
	.arst_n               (arst_n),
	.out_valid            (result.valid),
	.out_ready            (result.ready),
	.temperature_centi    (result.temperature_centi),
	.pressure_centipascal (result.pressure_centipascal),
	.humidity_q10         (result.humidity_q10),
	.pressure_fallback    (result.pressure_fallback)
);
